// ===== rtl/btgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr_pkg
// shared types, codes and constants of the bitmap text glyph renderer
// ----------------------------------------------------------------------------
package btgr_pkg;

    localparam int GLYPH_COUNT_DEF = 28;
    localparam int GLYPH_ROWS      = 8;
    localparam int ROW_W           = $clog2(GLYPH_ROWS);
    localparam int GLYPH_W         = 5;
    localparam int MEM_AW          = 8;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    // result kinds
    localparam logic KIND_SPAN  = 1'b0;
    localparam logic KIND_UNDER = 1'b1;

    // effect codes
    localparam logic [2:0] EFF_PLAIN      = 3'd0;
    localparam logic [2:0] EFF_RAMP       = 3'd1;
    localparam logic [2:0] EFF_UNDER      = 3'd2;
    localparam logic [2:0] EFF_RAMP_UNDER = 3'd3;
    localparam logic [2:0] EFF_BOLD       = 3'd4;
    localparam logic [2:0] EFF_BOLD_UNDER = 3'd5;

    // character codes and glyph numbers
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [GLYPH_W-1:0] GLYPH_COMMA  = 5'd26;
    localparam logic [GLYPH_W-1:0] GLYPH_PERIOD = 5'd27;

    // cursor
    localparam logic [10:0] ADV_NARROW = 11'd5;
    localparam logic [10:0] ADV_WIDE   = 11'd8;
    localparam logic [9:0]  CURSOR_MAX = 10'd1023;
    localparam logic [10:0] UNDER_DY   = 11'd8;

    typedef struct packed {
        logic       req_type;
        logic [7:0] font_index;
        logic [7:0] font_byte;
        logic [7:0] char_code;
        logic       first_of_string;
        logic [9:0] start_x;
        logic [9:0] start_y;
        logic [7:0] base_color;
        logic [2:0] effect;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [11:0] px;
        logic [10:0]        py;
        logic [7:0]         mask;
        logic [7:0]         pen_color;
        logic               ramp;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } t_mem_req;

endpackage

// ===== rtl/btgr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface btgr_in_if;
    logic               valid;
    logic               ready;
    btgr_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface btgr_out_if;
    logic                valid;
    logic                ready;
    btgr_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/btgr_glyph_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr_glyph_mem
// glyph store, one write and one registered read port
// ----------------------------------------------------------------------------
module btgr_glyph_mem #(
    parameter int GLYPH_COUNT = btgr_pkg::GLYPH_COUNT_DEF
) (
    input  logic               i_clk,
    input  btgr_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);
    localparam int DEPTH = GLYPH_COUNT * btgr_pkg::GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/btgr_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btgr_seq
// cursor, row sequencer and result register of the glyph renderer
// ----------------------------------------------------------------------------
module btgr_seq #(
    parameter int GLYPH_COUNT = btgr_pkg::GLYPH_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    btgr_in_if.sink            i_in,
    btgr_out_if.source         o_out,
    output btgr_pkg::t_mem_req o_mem_req,
    input  logic [7:0]         i_mem_rdata
);
    localparam int DEPTH = GLYPH_COUNT * btgr_pkg::GLYPH_ROWS;
    localparam int RW    = btgr_pkg::ROW_W;
    localparam int GW    = btgr_pkg::GLYPH_W;
    localparam logic [RW-1:0] ROW_LAST = RW'(btgr_pkg::GLYPH_ROWS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_SPAN  = 2'd3;

    function automatic logic [3:0] lit_count(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(b[k]);
        end
        return n;
    endfunction

    logic [1:0]          r_state, n_state;
    logic [9:0]          r_cx, n_cx;
    logic [9:0]          r_cy, n_cy;
    logic [GW-1:0]       r_glyph, n_glyph;
    logic [RW-1:0]       r_row, n_row;
    logic                r_pass, n_pass;
    logic                r_ramp_on, n_ramp_on;
    logic                r_under_on, n_under_on;
    logic                r_bold_on, n_bold_on;
    logic [7:0]          r_base, n_base;
    logic [7:0]          r_col, n_col;
    logic                r_out_valid, n_out_valid;
    btgr_pkg::t_out_item r_out, n_out;

    logic          in_acc;
    logic          slot_free;
    logic [10:0]   adv_sum;
    logic          mapped;
    logic [GW-1:0] glyph;
    logic [11:0]   x_pass;
    logic [7:0]    ch;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign slot_free   = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign ch          = i_in.data.char_code;
    assign x_pass      = 12'({2'b00, r_cx}) + 12'(r_pass);

    always_comb begin
        mapped = 1'b1;
        glyph  = GW'(ch - btgr_pkg::CH_A);
        if (ch == btgr_pkg::CH_COMMA) begin
            glyph = btgr_pkg::GLYPH_COMMA;
        end else if (ch == btgr_pkg::CH_PERIOD) begin
            glyph = btgr_pkg::GLYPH_PERIOD;
        end else if (ch < btgr_pkg::CH_A || ch > btgr_pkg::CH_Z) begin
            mapped = 1'b0;
        end
    end

    // saturating advance
    assign adv_sum = {1'b0, r_cx} +
        ((ch == btgr_pkg::CH_COMMA || ch == btgr_pkg::CH_PERIOD) ?
         btgr_pkg::ADV_NARROW : btgr_pkg::ADV_WIDE);

    always_comb begin
        o_mem_req.we    = in_acc && (i_in.data.req_type == btgr_pkg::REQ_LOAD) &&
                          ({1'b0, i_in.data.font_index} < 9'(DEPTH));
        o_mem_req.waddr = i_in.data.font_index;
        o_mem_req.wdata = i_in.data.font_byte;
        o_mem_req.re    = (r_state == ST_READ);
        o_mem_req.raddr = btgr_pkg::MEM_AW'({r_glyph, r_row});
    end

    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_glyph     = r_glyph;
        n_row       = r_row;
        n_pass      = r_pass;
        n_ramp_on   = r_ramp_on;
        n_under_on  = r_under_on;
        n_bold_on   = r_bold_on;
        n_base      = r_base;
        n_col       = r_col;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.data.req_type == btgr_pkg::REQ_DRAW) begin
                    if (i_in.data.first_of_string) begin
                        n_cx = i_in.data.start_x;
                        n_cy = i_in.data.start_y;
                    end else if (adv_sum > {1'b0, btgr_pkg::CURSOR_MAX}) begin
                        n_cx = btgr_pkg::CURSOR_MAX;
                    end else begin
                        n_cx = adv_sum[9:0];
                    end
                    n_glyph    = glyph;
                    n_row      = '0;
                    n_pass     = 1'b0;
                    n_base     = i_in.data.base_color;
                    n_col      = i_in.data.base_color;
                    n_ramp_on  = i_in.data.effect inside
                                 {btgr_pkg::EFF_RAMP, btgr_pkg::EFF_RAMP_UNDER};
                    n_under_on = i_in.data.effect inside
                                 {btgr_pkg::EFF_UNDER, btgr_pkg::EFF_RAMP_UNDER,
                                  btgr_pkg::EFF_BOLD_UNDER};
                    n_bold_on  = i_in.data.effect inside
                                 {btgr_pkg::EFF_BOLD, btgr_pkg::EFF_BOLD_UNDER};
                    if (mapped) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = r_under_on ? ST_UNDER : ST_SPAN;
            end
            ST_UNDER: begin
                if (slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = btgr_pkg::KIND_UNDER;
                    n_out.px        = $signed(x_pass + 12'(r_row) - 12'd1);
                    n_out.py        = 11'({1'b0, r_cy}) + btgr_pkg::UNDER_DY;
                    n_out.mask      = 8'd0;
                    n_out.pen_color = r_col;
                    n_out.ramp      = 1'b0;
                    n_out.last      = 1'b0;
                    n_state         = ST_SPAN;
                end
            end
            ST_SPAN: begin
                if (slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = btgr_pkg::KIND_SPAN;
                    n_out.px        = $signed(x_pass);
                    n_out.py        = 11'({1'b0, r_cy}) + 11'(r_row);
                    n_out.mask      = i_mem_rdata;
                    n_out.pen_color = r_col;
                    n_out.ramp      = r_ramp_on;
                    n_out.last      = (r_row == ROW_LAST) && (r_pass || !r_bold_on);
                    if (r_ramp_on) begin
                        n_col = r_col + 8'(lit_count(i_mem_rdata));
                    end
                    if (r_row == ROW_LAST) begin
                        n_row = '0;
                        if (r_bold_on && !r_pass) begin
                            n_pass  = 1'b1;
                            n_col   = r_base;
                            n_state = ST_READ;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_row   = r_row + RW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cx        <= '0;
            r_cy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_out_valid <= n_out_valid;
        end
        r_glyph    <= n_glyph;
        r_row      <= n_row;
        r_pass     <= n_pass;
        r_ramp_on  <= n_ramp_on;
        r_under_on <= n_under_on;
        r_bold_on  <= n_bold_on;
        r_base     <= n_base;
        r_col      <= n_col;
        r_out      <= n_out;
    end
endmodule

// ===== rtl/bitmap_text_glyph_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_glyph_renderer
// draws 8x8 bitmap glyphs from a loadable glyph store as row spans
// ----------------------------------------------------------------------------
// A load item (req_type 0) writes one byte of the glyph store; indexes past
// the store are dropped. A draw item (req_type 1) moves the text
// cursor and, for 'A'-'Z', comma and period, streams one span per glyph row,
// optionally preceded by an underline pixel, and a second pass one column to
// the right for bold. Each row is a glyph store read (ST_READ), then the
// underline pixel if any (ST_UNDER) and the span (ST_SPAN); a result waits
// in its state while the result register is full and the sink stalls. A
// space or any other unmapped character only moves the cursor and leaves
// the block idle. The single read port of the glyph store and the one-entry
// result register make the block walk its rows one result at a time. A new
// item is taken as soon as the last result of the previous one sits in the
// result register.
// The store has no reset: drawing a glyph whose rows were never loaded
// gives undefined masks.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_renderer #(
    parameter int GLYPH_COUNT = btgr_pkg::GLYPH_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btgr_in_if.sink    i_in,
    btgr_out_if.source o_out
);
    btgr_pkg::t_mem_req mem_req;
    logic [7:0]         mem_rdata;

    // cursor, row walk and result register
    btgr_seq #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // glyph rows, read into a register ahead of each span
    btgr_glyph_mem #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // loads only happen between characters, never while a row read is issued
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("glyph store written during a row read");

    // a load item never blocks the next item
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.data.req_type == btgr_pkg::REQ_LOAD)
        |=> i_in.ready)
        else $error("load item held the block busy");

    // underline results carry no mask and no ramp
    a_under_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.kind == btgr_pkg::KIND_UNDER)
        |-> (o_out.data.mask == 8'd0 && !o_out.data.ramp && !o_out.data.last))
        else $error("malformed underline result");

    // the final result of a character frees the input side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.last && !$stable(o_out.data)) |-> i_in.ready)
        else $error("input not ready after final result");
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking testbench of the bitmap text glyph renderer
// ----------------------------------------------------------------------------
// First the rows of a fixed set of glyphs are loaded, and only those glyphs
// are ever drawn. Then a short table of directed items covers cursor reset,
// the screen corners, cursor saturation, every effect, unmapped characters
// and loads past the store. After that come random strings mixed with
// random store loads. A local copy of the glyph store and of the text
// cursor predicts each span and underline pixel. Every result taken from
// the block is compared field by field with the oldest prediction. Both
// channels stall at random, except in one window of items where they run
// without gaps.
// ----------------------------------------------------------------------------
module tb;

    localparam int STORE_BYTES  = btgr_pkg::GLYPH_COUNT_DEF * btgr_pkg::GLYPH_ROWS;
    localparam int RANDOM_ITEMS = 46;
    localparam int IDLE_PCT     = 32;
    localparam int STEADY_FIRST = 110;     // window of items with no idling
    localparam int STEADY_LAST  = 140;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int NO_CHECK     = -1;

    // glyphs whose rows are loaded: A B G K L M Q Z comma period
    localparam logic [31:0] LOADED_MASK = 32'h0E01_1C43;

    // effect codes 6 and 7 fall back to plain drawing
    localparam logic [2:0] EFF_SPARE_6 = 3'd6;
    localparam logic [2:0] EFF_SPARE_7 = 3'd7;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    // one row of the directed table; exp_n and exp_px are the number of
    // results and the column of the first one, NO_CHECK where not typed in
    typedef struct packed {
        logic       req;
        logic [7:0] ch;
        logic       first;
        logic [9:0] sx;
        logic [9:0] sy;
        logic [7:0] color;
        logic [2:0] eff;
        logic [7:0] idx;
        logic [7:0] fbyte;
        int         exp_n;
        int         exp_px;
    } t_row;

    // an item waiting to be sent, with what the table says it must cause
    typedef struct packed {
        btgr_pkg::t_in_item item;
        int                 exp_n;
        int                 exp_px;
    } t_request;

    localparam int DIRECTED_ROWS = 24;

    t_row directed_rows [DIRECTED_ROWS] = '{
        // first character after reset: cursor starts at zero and moves by 8
        '{btgr_pkg::REQ_DRAW, btgr_pkg::CH_A, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 8, 8},
        // top left corner, underline starts one column left of the screen
        '{btgr_pkg::REQ_DRAW, "B", 1'b1, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_UNDER, 8'd0, 8'h00, 16, -1},
        // narrow advance for period and comma
        '{btgr_pkg::REQ_DRAW, btgr_pkg::CH_PERIOD, 1'b0, 10'd0, 10'd0, 8'd17,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 8, 5},
        '{btgr_pkg::REQ_DRAW, btgr_pkg::CH_COMMA, 1'b0, 10'd0, 10'd0, 8'd255,
          btgr_pkg::EFF_RAMP, 8'd0, 8'h00, 8, 10},
        // space moves the cursor and draws nothing
        '{btgr_pkg::REQ_DRAW, CH_SPACE, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 0, 0},
        '{btgr_pkg::REQ_DRAW, btgr_pkg::CH_Z, 1'b0, 10'd0, 10'd0, 8'd128,
          btgr_pkg::EFF_RAMP_UNDER, 8'd0, 8'h00, 16, 25},
        // bottom right corner, the most results one character can cause
        '{btgr_pkg::REQ_DRAW, "M", 1'b1, 10'd1023, 10'd1023, 8'd255,
          btgr_pkg::EFF_BOLD_UNDER, 8'd0, 8'h00, 32, 1022},
        // cursor saturates at the right edge
        '{btgr_pkg::REQ_DRAW, "Q", 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_BOLD, 8'd0, 8'h00, 16, 1023},
        '{btgr_pkg::REQ_DRAW, btgr_pkg::CH_PERIOD, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 8, 1023},
        // characters without a glyph, some just outside the mapped ranges
        '{btgr_pkg::REQ_DRAW, 8'hFF, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 0, 0},
        '{btgr_pkg::REQ_DRAW, "a", 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_BOLD, 8'd0, 8'h00, 0, 0},
        '{btgr_pkg::REQ_DRAW, "@", 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_UNDER, 8'd0, 8'h00, 0, 0},
        '{btgr_pkg::REQ_DRAW, "[", 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_RAMP, 8'd0, 8'h00, 0, 0},
        '{btgr_pkg::REQ_DRAW, "-", 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 0, 0},
        '{btgr_pkg::REQ_DRAW, 8'h00, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 0, 0},
        // spare effect codes draw plain
        '{btgr_pkg::REQ_DRAW, "K", 1'b1, 10'd512, 10'd341, 8'd85,
          EFF_SPARE_6, 8'd0, 8'h00, 8, 512},
        '{btgr_pkg::REQ_DRAW, "L", 1'b0, 10'd0, 10'd0, 8'd170,
          EFF_SPARE_7, 8'd0, 8'h00, 8, 520},
        // loads past the store are dropped, the last byte is kept
        '{btgr_pkg::REQ_LOAD, 8'h00, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd224, 8'hFF, 0, 0},
        '{btgr_pkg::REQ_LOAD, 8'h00, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd255, 8'hAA, 0, 0},
        '{btgr_pkg::REQ_LOAD, 8'h00, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd223, 8'h81, 0, 0},
        '{btgr_pkg::REQ_DRAW, btgr_pkg::CH_PERIOD, 1'b1, 10'd682, 10'd682, 8'd0,
          btgr_pkg::EFF_RAMP, 8'd0, 8'h00, 8, 682},
        '{btgr_pkg::REQ_DRAW, "G", 1'b0, 10'd0, 10'd0, 8'd1,
          btgr_pkg::EFF_BOLD, 8'd0, 8'h00, 16, 690},
        // overwrite the first byte of the store, then draw that glyph
        '{btgr_pkg::REQ_LOAD, 8'h00, 1'b0, 10'd0, 10'd0, 8'd0,
          btgr_pkg::EFF_PLAIN, 8'd0, 8'h00, 0, 0},
        '{btgr_pkg::REQ_DRAW, btgr_pkg::CH_A, 1'b1, 10'd1, 10'd1000, 8'd200,
          btgr_pkg::EFF_BOLD_UNDER, 8'd0, 8'h00, 32, 0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    btgr_in_if  in_ch ();
    btgr_out_if out_ch ();

    bitmap_text_glyph_renderer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: copy of the glyph store and of the text cursor
    logic [7:0] font_copy [STORE_BYTES];
    int         text_x = 0;
    int         text_y = 0;

    t_request            request_q [$];
    btgr_pkg::t_out_item predicted_draws [$];
    int                  req_total    = 0;
    int                  req_issued   = 0;
    int                  req_taken    = 0;
    int                  mismatch_cnt = 0;
    int                  cycle_cnt    = 0;

    function automatic void report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic string draw_str(input btgr_pkg::t_out_item r);
        return $sformatf("kind %0d px %0d py %0d mask %02h pen %02h ramp %0d last %0d",
                         r.kind, $signed(r.px), r.py, r.mask, r.pen_color, r.ramp,
                         r.last);
    endfunction

    // every field random, so that fields an item does not use are exercised
    function automatic btgr_pkg::t_in_item random_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(btgr_pkg::t_in_item)-1:0];
    endfunction

    // glyph number of a character, -1 where it has none
    function automatic int glyph_of(input logic [7:0] c);
        if (c >= btgr_pkg::CH_A && c <= btgr_pkg::CH_Z) begin
            return int'(c - btgr_pkg::CH_A);
        end
        if (c == btgr_pkg::CH_COMMA) begin
            return int'(btgr_pkg::GLYPH_COMMA);
        end
        if (c == btgr_pkg::CH_PERIOD) begin
            return int'(btgr_pkg::GLYPH_PERIOD);
        end
        return -1;
    endfunction

    // updates the store copy and the cursor for one item and queues the
    // spans and underline pixels it draws; returns their number and the
    // column of the first one
    function automatic int predict_draw(input btgr_pkg::t_in_item it,
                                        output int first_px);
        int                  glyph, passes, total, n, p, r, adv;
        logic [7:0]          col, bits;
        logic                ramp_on, under_on, bold_on;
        btgr_pkg::t_out_item res;
        first_px = 0;
        if (it.req_type == btgr_pkg::REQ_LOAD) begin
            if (int'(it.font_index) < STORE_BYTES) begin
                font_copy[it.font_index] = it.font_byte;
            end
            return 0;
        end

        if (it.first_of_string) begin
            text_x = int'(it.start_x);
            text_y = int'(it.start_y);
        end else begin
            adv = (it.char_code == btgr_pkg::CH_COMMA ||
                   it.char_code == btgr_pkg::CH_PERIOD) ?
                  int'(btgr_pkg::ADV_NARROW) : int'(btgr_pkg::ADV_WIDE);
            text_x = (text_x + adv > int'(btgr_pkg::CURSOR_MAX)) ?
                     int'(btgr_pkg::CURSOR_MAX) : text_x + adv;
        end

        glyph = glyph_of(it.char_code);
        if (glyph < 0) begin
            return 0;
        end

        ramp_on  = (it.effect == btgr_pkg::EFF_RAMP) ||
                   (it.effect == btgr_pkg::EFF_RAMP_UNDER);
        under_on = (it.effect == btgr_pkg::EFF_UNDER) ||
                   (it.effect == btgr_pkg::EFF_RAMP_UNDER) ||
                   (it.effect == btgr_pkg::EFF_BOLD_UNDER);
        bold_on  = (it.effect == btgr_pkg::EFF_BOLD) ||
                   (it.effect == btgr_pkg::EFF_BOLD_UNDER);
        passes   = bold_on ? 2 : 1;
        total    = passes * btgr_pkg::GLYPH_ROWS * (under_on ? 2 : 1);
        first_px = under_on ? text_x - 1 : text_x;
        n = 0;
        for (p = 0; p < passes; p++) begin
            col = it.base_color;
            for (r = 0; r < btgr_pkg::GLYPH_ROWS; r++) begin
                bits = font_copy[glyph * btgr_pkg::GLYPH_ROWS + r];
                if (under_on) begin
                    res           = '0;
                    res.kind      = btgr_pkg::KIND_UNDER;
                    res.px        = 12'(text_x + p + r - 1);
                    res.py        = 11'(text_y + int'(btgr_pkg::UNDER_DY));
                    res.pen_color = col;
                    n++;
                    res.last      = (n == total);
                    predicted_draws.push_back(res);
                end
                res           = '0;
                res.kind      = btgr_pkg::KIND_SPAN;
                res.px        = 12'(text_x + p);
                res.py        = 11'(text_y + r);
                res.mask      = bits;
                res.pen_color = col;
                res.ramp      = ramp_on;
                n++;
                res.last      = (n == total);
                predicted_draws.push_back(res);
                if (ramp_on) begin
                    col = col + 8'($countones(bits));
                end
            end
        end
        return n;
    endfunction

    function automatic void check_draw(input btgr_pkg::t_out_item got);
        btgr_pkg::t_out_item want;
        if (predicted_draws.size() == 0) begin
            report_mismatch({"result with nothing predicted: ", draw_str(got)});
            return;
        end
        want = predicted_draws.pop_front();
        if (got.kind !== want.kind || got.px !== want.px || got.py !== want.py ||
            got.mask !== want.mask || got.pen_color !== want.pen_color ||
            got.ramp !== want.ramp || got.last !== want.last) begin
            report_mismatch({"expected ", draw_str(want), ", got ", draw_str(got)});
        end
    endfunction

    // both channels run without gaps inside this window of items
    function automatic logic steady_window();
        return (req_issued >= STEADY_FIRST) && (req_issued < STEADY_LAST);
    endfunction

    // input channel: hold an item until taken, then predict its results
    initial begin : request_driver
        int       n, first_px;
        t_request req_on_bus;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        req_on_bus  = '0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                in_ch.valid <= 1'b0;
            end else begin
                if (in_ch.valid && in_ch.ready) begin
                    n = predict_draw(req_on_bus.item, first_px);
                    req_taken <= req_taken + 1;
                    // typed-in table values must agree with the prediction
                    if (req_on_bus.exp_n != NO_CHECK &&
                        (n != req_on_bus.exp_n ||
                         (n != 0 && first_px != req_on_bus.exp_px))) begin
                        report_mismatch($sformatf(
                            "item %0d: %0d results from x %0d, table says %0d from x %0d",
                            req_taken, n, first_px, req_on_bus.exp_n, req_on_bus.exp_px));
                    end
                end
                if (!in_ch.valid || in_ch.ready) begin
                    if (request_q.size() != 0 &&
                        (steady_window() || $urandom_range(99) >= IDLE_PCT)) begin
                        req_on_bus = request_q.pop_front();
                        in_ch.data  <= req_on_bus.item;
                        in_ch.valid <= 1'b1;
                        req_issued  <= req_issued + 1;
                    end else begin
                        in_ch.valid <= 1'b0;
                    end
                end
            end
        end
    end

    // result channel: random back-pressure, every taken result is checked
    initial begin : result_sink
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                if (out_ch.valid && out_ch.ready) begin
                    check_draw(out_ch.data);
                end
                out_ch.ready <= steady_window() || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        btgr_pkg::t_in_item it;
        int                 k, g, r, pick;

        // load every row of the glyphs in use so that no row drawn is unwritten;
        // the first two rows of each glyph are all-lit and all-dark
        for (g = 0; g < btgr_pkg::GLYPH_COUNT_DEF; g++) begin
            if (LOADED_MASK[g]) begin
                for (r = 0; r < btgr_pkg::GLYPH_ROWS; r++) begin
                    k             = g * btgr_pkg::GLYPH_ROWS + r;
                    it            = random_fields();
                    it.req_type   = btgr_pkg::REQ_LOAD;
                    it.font_index = 8'(k);
                    it.font_byte  = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom);
                    request_q.push_back('{it, NO_CHECK, 0});
                end
            end
        end

        // directed table
        for (k = 0; k < DIRECTED_ROWS; k++) begin
            it          = random_fields();
            it.req_type = directed_rows[k].req;
            if (it.req_type == btgr_pkg::REQ_LOAD) begin
                it.font_index = directed_rows[k].idx;
                it.font_byte  = directed_rows[k].fbyte;
            end else begin
                it.char_code       = directed_rows[k].ch;
                it.first_of_string = directed_rows[k].first;
                it.base_color      = directed_rows[k].color;
                it.effect          = directed_rows[k].eff;
                if (directed_rows[k].first) begin
                    it.start_x = directed_rows[k].sx;
                    it.start_y = directed_rows[k].sy;
                end
            end
            request_q.push_back('{it, directed_rows[k].exp_n, directed_rows[k].exp_px});
        end

        // random strings of mostly mapped characters, with store rewrites,
        // out-of-range loads, spaces and arbitrary codes mixed in
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            it = random_fields();
            if ($urandom_range(99) < 15) begin
                it.req_type = btgr_pkg::REQ_LOAD;
            end else begin
                it.req_type        = btgr_pkg::REQ_DRAW;
                it.first_of_string = ($urandom_range(5) == 0);
                if ($urandom_range(4) == 0) begin
                    it.start_x = 10'($urandom_range(1023, 1000));
                end
                pick = $urandom_range(99);
                if (pick < 60) begin
                    do begin
                        it.char_code = btgr_pkg::CH_A + 8'($urandom_range(25));
                    end while (!LOADED_MASK[glyph_of(it.char_code)]);
                end else if (pick < 72) begin
                    it.char_code = $urandom_range(1) ? btgr_pkg::CH_COMMA :
                                                       btgr_pkg::CH_PERIOD;
                end else if (pick < 82) begin
                    it.char_code = CH_SPACE;
                end else begin
                    // arbitrary code; a letter whose rows are not loaded is a space
                    g = glyph_of(it.char_code);
                    if (g >= 0 && !LOADED_MASK[g]) begin
                        it.char_code = CH_SPACE;
                    end
                end
            end
            request_q.push_back('{it, NO_CHECK, 0});
        end
        req_total = request_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every item to be taken and every prediction to be met
        while (req_taken != req_total || predicted_draws.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/btgr_pkg.sv
rtl/btgr_if.sv
rtl/btgr_glyph_mem.sv
rtl/btgr_seq.sv
rtl/bitmap_text_glyph_renderer.sv
sim/tb.sv
